// ===== src/lmfe_pkg.sv =====
// ---------------------------------------------------------------------------
// Label map face extraction package
// Field widths, opcodes and reset values shared by the face extraction core.
// ---------------------------------------------------------------------------
package lmfe_pkg;

   localparam int LABEL_W    = 8;
   localparam int OPCODE_W   = 1;
   localparam int CFG_W      = 11;
   localparam int PIXEL_X_W  = 10;
   localparam int PIXEL_Y_W  = 12;
   localparam int MASK_W     = 6;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   localparam logic [OPCODE_W-1:0] OP_PIXEL = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_FLUSH = 1'b1;

   localparam logic [CFG_W-1:0]     WIDTH_RESET = 11'd1024;
   localparam logic [PIXEL_Y_W-1:0] Y_SAT       = 12'd4095;

   // Face mask bit positions.
   localparam int FACE_LEFT   = 0;
   localparam int FACE_RIGHT  = 1;
   localparam int FACE_TOP_EX = 2;
   localparam int FACE_BOT_EX = 3;
   localparam int FACE_UP     = 4;
   localparam int FACE_DOWN   = 5;

   typedef struct packed {
      logic [PIXEL_X_W-1:0] pixel_x;
      logic [PIXEL_Y_W-1:0] pixel_y;
      logic [LABEL_W-1:0]   pixel_label;
      logic [MASK_W-1:0]    face_mask;
   } rsp_fields_type;

endpackage

// ===== src/label_map_face_extraction_core.sv =====
// ---------------------------------------------------------------------------
// Label map face extraction core
// Streams label pixels through a line buffer and reports the exposed faces of
// each cell of the previous row.
// Pipeline: a request passes through the stage 1 register, then the output register.
// Throughput: one request per cycle unless a held response stalls stage 1.
// Reset clears the position counters and the pipeline; the line buffers have
// no clearing pass and hold garbage until the first row writes them.
// ---------------------------------------------------------------------------
module label_map_face_extraction_core
   import lmfe_pkg::*;
#(
   parameter int WIDTH_MAX  = 1024,
   parameter int HEIGHT_MAX = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] label
   input  logic [OPCODE_W-1:0]   req_tuser,   // [0] opcode
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [9:0] pixel_x, [21:10] pixel_y, [29:22] pixel_label, [35:30] face_mask,
   // [39:36] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,   // frame_end
   // Configuration.
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data  // image_width
);

   localparam int CW = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
   localparam int LW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int RW = $clog2(HEIGHT_MAX + 1);

   // Line buffers.
   logic [LABEL_W-1:0] row_mem [WIDTH_MAX];
   logic               up_mem  [WIDTH_MAX];

   // Configuration and frame position.
   logic [CFG_W-1:0] width_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             flushing_ff, flushing_in;

   // Stage 1: accepted request with line buffer read data.
   logic                 s1_valid_ff, s1_valid_in;
   logic [CW-1:0]        s1_col_ff;
   logic                 s1_last_ff;
   logic                 s1_right_ok_ff;
   logic                 s1_has_rsp_ff;
   logic                 s1_frame_end_ff;
   logic [PIXEL_Y_W-1:0] s1_y_ff;
   logic [LABEL_W-1:0]   s1_cur_ff;
   logic [LABEL_W-1:0]   rd_p_ff, rd_r_ff;
   logic                 rd_up_ff;
   logic                 fwd_p_ff, fwd_r_ff;
   logic [LABEL_W-1:0]   fwd_label_ff;
   logic                 fwd_up_ff;
   logic [LABEL_W-1:0]   left_ff, left_in;

   // Output register.
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_fields_type rsp_ff;
   logic           rsp_last_ff;

   // Request side decode.
   logic                 req_accept;
   logic [LW-1:0]        w_act;
   logic [LW-1:0]        col_next;
   logic                 last;
   logic                 right_ok;
   logic                 flush_now;
   logic [LABEL_W-1:0]   cur;
   logic [CW-1:0]        rd_r_addr;
   logic [RW+11:0]       y_ext;
   logic [PIXEL_Y_W-1:0] y_val;

   // Stage 1 evaluation.
   logic               s1_move;
   logic [LABEL_W-1:0] p_val, right_val, above;
   logic               up_val;
   logic [MASK_W-1:0]  mask;
   logic               wr_up;
   logic [CW+9:0]      x_ext;

   always_comb begin
      w_act = LW'(width_ff);
      if (width_ff == '0) begin
         w_act = LW'(1);
      end else if (LW'(width_ff) > LW'(WIDTH_MAX)) begin
         w_act = LW'(WIDTH_MAX);
      end
      col_next  = LW'(col_ff) + LW'(1);
      last      = (col_next >= w_act);
      right_ok  = !last && (col_next < LW'(WIDTH_MAX));
      rd_r_addr = right_ok ? CW'(col_next) : col_ff;
      flush_now = flushing_ff || (req_tuser == OP_FLUSH);
      cur       = (req_tuser == OP_FLUSH) ? '0 : req_tdata[LABEL_W-1:0];
      y_ext     = {12'b0, row_ff} - (RW + 12)'(1);
      y_val     = (y_ext > (RW + 12)'(Y_SAT)) ? Y_SAT : y_ext[PIXEL_Y_W-1:0];
   end

   // Stage 1 moves on when its result, if any, has a free output register.
   assign s1_move    = s1_valid_ff &&
                       (!s1_has_rsp_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      flushing_in = flushing_ff;
      if (req_accept) begin
         if (last) begin
            col_in      = '0;
            flushing_in = 1'b0;
            if (flush_now) begin
               row_in = '0;
            end else if (row_ff < RW'(HEIGHT_MAX)) begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in      = CW'(col_next);
            flushing_in = flush_now;
         end
      end
   end

   // A write retiring on the same edge as the read is forwarded.
   always_comb begin
      p_val     = fwd_p_ff ? fwd_label_ff : rd_p_ff;
      right_val = !s1_right_ok_ff ? '0 : (fwd_r_ff ? fwd_label_ff : rd_r_ff);
      up_val    = fwd_p_ff ? fwd_up_ff : rd_up_ff;
      above     = s1_has_rsp_ff ? p_val : '0;
      wr_up     = (s1_cur_ff != above);
      mask      = '0;
      if (p_val != '0) begin
         mask[FACE_LEFT]   = (p_val != left_ff);
         mask[FACE_RIGHT]  = (p_val != right_val);
         mask[FACE_TOP_EX] = 1'b1;
         mask[FACE_BOT_EX] = 1'b1;
         mask[FACE_UP]     = up_val;
         mask[FACE_DOWN]   = (s1_cur_ff != p_val);
      end
      x_ext   = {10'b0, s1_col_ff};
      left_in = left_ff;
      if (s1_move) begin
         if (s1_last_ff) begin
            left_in = '0;
         end else if (s1_has_rsp_ff) begin
            left_in = p_val;
         end
      end
   end

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = (s1_move && s1_has_rsp_ff) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         flushing_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         flushing_ff  <= flushing_in;
         s1_valid_ff  <= s1_valid_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff       <= col_ff;
         s1_last_ff      <= last;
         s1_right_ok_ff  <= right_ok;
         s1_has_rsp_ff   <= (row_ff != '0);
         s1_frame_end_ff <= flush_now && last;
         s1_y_ff         <= y_val;
         s1_cur_ff       <= cur;
         rd_p_ff         <= row_mem[col_ff];
         rd_r_ff         <= row_mem[rd_r_addr];
         rd_up_ff        <= up_mem[col_ff];
         fwd_p_ff        <= s1_move && (s1_col_ff == col_ff);
         fwd_r_ff        <= s1_move && (s1_col_ff == rd_r_addr);
         fwd_label_ff    <= s1_cur_ff;
         fwd_up_ff       <= wr_up;
      end
      if (s1_move) begin
         row_mem[s1_col_ff] <= s1_cur_ff;
         up_mem[s1_col_ff]  <= wr_up;
      end
      if (s1_move && s1_has_rsp_ff) begin
         rsp_ff.pixel_x     <= x_ext[PIXEL_X_W-1:0];
         rsp_ff.pixel_y     <= s1_y_ff;
         rsp_ff.pixel_label <= p_val;
         rsp_ff.face_mask   <= mask;
         rsp_last_ff        <= s1_frame_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.face_mask, rsp_ff.pixel_label,
                        rsp_ff.pixel_y, rsp_ff.pixel_x};

   // The column counter never leaves the line buffer.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      LW'(col_ff) < LW'(WIDTH_MAX))
      else $error("column counter beyond line buffer depth");

   // An empty cell has no faces, a labelled one always has both extrusions.
   a_mask_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.pixel_label == '0) == (rsp_ff.face_mask == '0)))
      else $error("face mask does not match label");

   // The last request of a flush row restarts the frame.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && last && flush_now) |=> (row_ff == '0) && !flushing_ff)
      else $error("frame did not restart after flush row");

   // Back pressure only comes from a held stage 1 item.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s1_has_rsp_ff && rsp_valid_ff))
      else $error("request stalled without a held result");

endmodule
